/* rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file of the alert mail burst limiter
// no dependencies; the including module must provide clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AMB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amb assertion failed");

// next-cycle implication, disabled during reset
`define AMB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amb assertion failed");

`endif

/* rtl/amb_pkg.sv */
// types, codes and constants of the alert mail burst limiter
// no dependencies
package amb_pkg;

    localparam int TIME_W          = 32;
    localparam int LEN_W           = 7;
    localparam int DLEN_W          = 10;
    localparam int SENT_W          = 8;
    localparam int SUPP_W          = 16;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int DIGEST_CAPACITY = 1024;
    localparam int DIGEST_RESERVE  = 40;
    localparam int DIGEST_LIMIT_RESET_I =
        (DIGEST_CAPACITY - DIGEST_RESERVE > 1023) ? 1023 : DIGEST_CAPACITY - DIGEST_RESERVE;

    localparam logic [DLEN_W-1:0] DIGEST_LIMIT_RESET = DLEN_W'(DIGEST_LIMIT_RESET_I);
    localparam logic [SENT_W-1:0] BURST_RESET        = SENT_W'(4);
    localparam logic [TIME_W-1:0] WINDOW_RESET       = TIME_W'(3600);
    localparam logic [TIME_W-1:0] COLLECT_RESET      = TIME_W'(3000);
    localparam logic [TIME_W-1:0] FLUSH_RESET        = TIME_W'(3540);
    // message plus separator headroom in the digest fit check
    localparam logic [DLEN_W:0]   DIGEST_HEADROOM    = (DLEN_W + 1)'(2);

    typedef enum logic [1:0] {
        MODE_ALARM = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_SEND  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_SINGLE     = 3'd1,
        ACT_COLLECTED  = 3'd2,
        ACT_SUPPRESSED = 3'd3,
        ACT_DIGEST     = 3'd4
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAIL_ENABLED   = 3'd0,
        REG_BURST_LIMIT    = 3'd1,
        REG_WINDOW_LENGTH  = 3'd2,
        REG_COLLECT_BEFORE = 3'd3,
        REG_FLUSH_AFTER    = 3'd4,
        REG_DIGEST_LIMIT   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic              mail_enabled;
        logic [SENT_W-1:0] burst_limit;
        logic [TIME_W-1:0] window_length;
        logic [TIME_W-1:0] collect_before;
        logic [TIME_W-1:0] flush_after;
        logic [DLEN_W-1:0] digest_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now_time;
        logic [LEN_W-1:0]  msg_len;
        logic              send_ok;
    } item_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [DLEN_W-1:0] mail_len;
        logic [SUPP_W-1:0] dropped_count;
        logic [SENT_W-1:0] sent_in_window;
        logic              collecting_now;
    } result_t;

endpackage

/* rtl/amb_item_if.sv */
// input channel of the alert mail burst limiter: valid, ready and item fields
// depends on amb_pkg
interface amb_item_if import amb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [TIME_W-1:0] now_time;
    logic [LEN_W-1:0]  msg_len;
    logic              send_ok;

    modport source (output valid, mode, now_time, msg_len, send_ok, input ready);
    modport sink   (input valid, mode, now_time, msg_len, send_ok, output ready);
endinterface

/* rtl/amb_result_if.sv */
// result channel of the alert mail burst limiter: valid, ready and result fields
// depends on amb_pkg
interface amb_result_if import amb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [DLEN_W-1:0] mail_len;
    logic [SUPP_W-1:0] dropped_count;
    logic [SENT_W-1:0] sent_in_window;
    logic              collecting_now;

    modport source (output valid, action, mail_len, dropped_count, sent_in_window,
                    collecting_now, input ready);
    modport sink   (input valid, action, mail_len, dropped_count, sent_in_window,
                    collecting_now, output ready);
endinterface

/* rtl/alert_mail_burst_limiter.sv */
// top level of the alert mail burst limiter: input stage, core, result register
// depends on amb_pkg, amb_item_if, amb_result_if, amb_cfg_regs, amb_core, assert_macros.svh
//
//   channel   direction  transaction
//   item      in         mode, now_time, msg_len, send_ok
//   result    out        action, mail_len, dropped_count, sent_in_window, collecting_now
//   wr_*      in         register write, index 0..5, no read-back
//
// an accepted item goes into the input register and from there, once the result
// register is free or being emptied, into the result register, where its result
// is valid; one item per cycle sustained while the result side is ready
// the window and digest state updates as the item moves from the input register
// to the result register
// reset clears the state and the valid flags and sets the config registers to defaults
// a stalled result holds the input register; the item side is ready while the
// input register is empty or empties in the same cycle
`include "assert_macros.svh"

module alert_mail_burst_limiter
    import amb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    amb_item_if.sink               item,
    amb_result_if.source           result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    cfg_t    cfg;
    item_t   stage_reg;
    logic    stage_valid_reg, stage_valid_next;
    result_t res_reg;
    result_t res_comb;
    logic    res_valid_reg, res_valid_next;
    logic    advance;
    logic    take_item;
    logic    res_in_digest;
    logic    res_is_digest;

    // configuration registers
    amb_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // the staged item moves on when the result register is free or being emptied
    assign advance   = stage_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || advance;
    assign take_item = item.valid && item.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take_item)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            stage_reg.mode     <= item.mode;
            stage_reg.now_time <= item.now_time;
            stage_reg.msg_len  <= item.msg_len;
            stage_reg.send_ok  <= item.send_ok;
        end
        if (advance)
            res_reg <= res_comb;
    end

    // window, burst and digest logic
    amb_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_reg),
        .cfg     (cfg),
        .result  (res_comb)
    );

    assign result.valid          = res_valid_reg;
    assign result.action         = res_reg.action;
    assign result.mail_len       = res_reg.mail_len;
    assign result.dropped_count  = res_reg.dropped_count;
    assign result.sent_in_window = res_reg.sent_in_window;
    assign result.collecting_now = res_reg.collecting_now;

    // result classes watched by the checks below
    assign res_in_digest = res_valid_reg
                           && (res_reg.action == ACT_COLLECTED
                               || res_reg.action == ACT_SUPPRESSED);
    assign res_is_digest = res_valid_reg && res_reg.action == ACT_DIGEST;

    // a collected or suppressed alarm always leaves collection active
    `AMB_ASSERT_NOW(a_digest_implies_collecting, res_in_digest, res_reg.collecting_now)
    // a digest mail is never empty and always ends collection
    `AMB_ASSERT_NOW(a_digest_not_empty, res_is_digest, res_reg.mail_len != '0 && !res_reg.collecting_now)
    // a staged item that moves on always shows up as a result next cycle
    `AMB_ASSERT_NEXT(a_advance_loads_result, advance, res_valid_reg)

endmodule

/* rtl/amb_cfg_regs.sv */
// configuration register file of the alert mail burst limiter
// depends on amb_pkg
module amb_cfg_regs
    import amb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_MAIL_ENABLED:   cfg_next.mail_enabled   = wr_data[0];
                REG_BURST_LIMIT:    cfg_next.burst_limit    = wr_data[SENT_W-1:0];
                REG_WINDOW_LENGTH:  cfg_next.window_length  = wr_data[TIME_W-1:0];
                REG_COLLECT_BEFORE: cfg_next.collect_before = wr_data[TIME_W-1:0];
                REG_FLUSH_AFTER:    cfg_next.flush_after    = wr_data[TIME_W-1:0];
                REG_DIGEST_LIMIT:   cfg_next.digest_limit   = wr_data[DLEN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mail_enabled   <= 1'b0;
            cfg_reg.burst_limit    <= BURST_RESET;
            cfg_reg.window_length  <= WINDOW_RESET;
            cfg_reg.collect_before <= COLLECT_RESET;
            cfg_reg.flush_after    <= FLUSH_RESET;
            cfg_reg.digest_limit   <= DIGEST_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/amb_core.sv */
// window, burst and digest state of the limiter with its per-item update logic
// depends on amb_pkg
module amb_core
    import amb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic              window_open_reg,  window_open_next;
    logic [TIME_W-1:0] window_start_reg, window_start_next;
    logic [SENT_W-1:0] sent_count_reg,   sent_count_next;
    logic              collecting_reg,   collecting_next;
    logic [DLEN_W-1:0] digest_len_reg,   digest_len_next;
    logic [SUPP_W-1:0] supp_count_reg,   supp_count_next;

    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] elapsed_eff;
    logic              new_window;
    logic [DLEN_W:0]   fit_sum;
    logic              fits;
    logic [DLEN_W-1:0] appended_len;
    logic [2:0]        action;
    logic [DLEN_W-1:0] mail_len;
    logic [SUPP_W-1:0] dropped;

    assign elapsed    = item.now_time - window_start_reg;
    assign new_window = !window_open_reg || (elapsed >= cfg.window_length);
    // a fresh window starts at the item time, so its elapsed time is zero
    assign elapsed_eff = new_window ? '0 : elapsed;

    // digest fit check runs on the post-window-check digest length
    always_comb
    begin
        logic [DLEN_W-1:0] base_len;
        base_len     = new_window ? '0 : digest_len_reg;
        fit_sum      = {1'b0, base_len} + (DLEN_W + 1)'(item.msg_len) + DIGEST_HEADROOM;
        fits         = fit_sum < {1'b0, cfg.digest_limit};
        appended_len = base_len + DLEN_W'(base_len != '0) + DLEN_W'(item.msg_len);
    end

    always_comb
    begin
        window_open_next  = window_open_reg;
        window_start_next = window_start_reg;
        sent_count_next   = sent_count_reg;
        collecting_next   = collecting_reg;
        digest_len_next   = digest_len_reg;
        supp_count_next   = supp_count_reg;
        action            = ACT_NONE;
        mail_len          = '0;
        dropped           = '0;

        case (mode_t'(item.mode))
            MODE_ALARM:
            begin
                if (cfg.mail_enabled)
                begin
                    if (new_window)
                    begin
                        window_open_next  = 1'b1;
                        window_start_next = item.now_time;
                        sent_count_next   = '0;
                        collecting_next   = 1'b0;
                        digest_len_next   = '0;
                        supp_count_next   = '0;
                    end
                    if (collecting_next
                        || (sent_count_next >= cfg.burst_limit
                            && elapsed_eff < cfg.collect_before))
                    begin
                        collecting_next = 1'b1;
                        if (fits)
                        begin
                            action          = ACT_COLLECTED;
                            digest_len_next = appended_len;
                        end
                        else
                        begin
                            action = ACT_SUPPRESSED;
                            if (supp_count_next != '1)
                                supp_count_next = supp_count_next + 1'b1;
                        end
                    end
                    else
                    begin
                        action   = ACT_SINGLE;
                        mail_len = DLEN_W'(item.msg_len);
                    end
                end
            end
            MODE_TICK:
            begin
                if (collecting_reg && window_open_reg && elapsed >= cfg.flush_after)
                begin
                    if (digest_len_reg != '0 && cfg.mail_enabled)
                    begin
                        action   = ACT_DIGEST;
                        mail_len = digest_len_reg;
                        dropped  = supp_count_reg;
                    end
                    // a due digest is discarded even when no mail can go out
                    digest_len_next = '0;
                    supp_count_next = '0;
                    collecting_next = 1'b0;
                end
            end
            MODE_SEND:
            begin
                if (item.send_ok && sent_count_reg != '1)
                    sent_count_next = sent_count_reg + 1'b1;
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_open_reg  <= 1'b0;
            window_start_reg <= '0;
            sent_count_reg   <= '0;
            collecting_reg   <= 1'b0;
            digest_len_reg   <= '0;
            supp_count_reg   <= '0;
        end
        else if (advance)
        begin
            window_open_reg  <= window_open_next;
            window_start_reg <= window_start_next;
            sent_count_reg   <= sent_count_next;
            collecting_reg   <= collecting_next;
            digest_len_reg   <= digest_len_next;
            supp_count_reg   <= supp_count_next;
        end
    end

    assign result.action         = action;
    assign result.mail_len       = mail_len;
    assign result.dropped_count  = dropped;
    assign result.sent_in_window = sent_count_next;
    assign result.collecting_now = collecting_next;

endmodule
